// ===== rtl/fgn_pkg.sv =====
// Shared constants, types and trig tables for the fractal gradient noise block.
package fgn_pkg;

	localparam int MAX_OCTAVES = 4;
	localparam int ANGLE_BITS  = 10;
	localparam int QTAB        = 1 << (ANGLE_BITS - 2);
	localparam int LATENCY     = 9;

	localparam logic [31:0] HASH_MUL_A  = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B  = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C  = 32'd2048419325;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_OCT_COUNT = 3'd0,
		REG_FREQ_0    = 3'd1,
		REG_FREQ_1    = 3'd2,
		REG_FREQ_2    = 3'd3,
		REG_FREQ_3    = 3'd4
	} cfg_reg_t;

	typedef logic [16:0] trig_t;
	typedef trig_t [QTAB-1:0] trig_tab_t;
	typedef logic signed [27:0] q24_t;

	// shift-subtract quotient, only used while building the tables
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// quarter-wave sin or cos in Q16, Taylor series in Q30, built at elaboration
	function automatic trig_tab_t build_tab(input bit want_sin);
		trig_tab_t tab;
		longint unsigned phi, st, ct;
		longint sacc, cacc, v;
		for (int r = 0; r < QTAB; r++) begin
			phi  = (longint'(r) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
			st   = phi;
			ct   = 64'd1 << 30;
			sacc = 0;
			cacc = 0;
			for (int n = 1; n <= 10; n++) begin
				if (n[0]) begin
					sacc += longint'(st);
					cacc += longint'(ct);
				end else begin
					sacc -= longint'(st);
					cacc -= longint'(ct);
				end
				st = (st * phi) >> 30;
				st = udiv64((st * phi) >> 30, 64'((2 * n) * (2 * n + 1)));
				ct = (ct * phi) >> 30;
				ct = udiv64((ct * phi) >> 30, 64'((2 * n - 1) * (2 * n)));
			end
			if (sacc < 0) sacc = 0;
			if (cacc < 0) cacc = 0;
			v = want_sin ? sacc : cacc;
			tab[r] = 17'((v + 8192) >>> 14);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b1);
	localparam trig_tab_t COS_TAB = build_tab(1'b0);

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// floor((a*(1-t) + b*t) / 2^16)
	function automatic q24_t mix(input q24_t a, input q24_t b, input logic [15:0] t);
		logic signed [17:0] wa, wb;
		logic signed [46:0] acc;
		wa  = $signed({1'b0, 17'(17'h10000 - {1'b0, t})});
		wb  = $signed({2'b00, t});
		acc = a * wa + b * wb;
		return acc[43:16];
	endfunction

endpackage

// ===== rtl/fgn_octave.sv =====
// One octave lane: scale, corner hash, gradient lookup, dot products and lerps.
module fgn_octave import fgn_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic        [15:0] freq,
	output q24_t               value
);

	logic signed [48:0] px_s1, py_s1;
	logic [31:0] a1_s2 [2];
	logic [31:0] cy_s2 [2];
	logic [15:0] tx_s2, ty_s2, tx_s3, ty_s3, tx_s4, ty_s4, tx_s5, ty_s5;
	logic [15:0] tx_s6, ty_s6, ty_s7;
	logic [31:0] a1_s3 [4];
	logic [31:0] b1_s3 [4];
	logic [31:0] h_s4 [4];
	logic signed [17:0] gx_s5 [4];
	logic signed [17:0] gy_s5 [4];
	q24_t dot_s6 [4];
	q24_t mx_s7 [2];
	q24_t val_s8;

	logic [31:0] cx0, cy0;
	assign cx0 = {{15{px_s1[48]}}, px_s1[48:32]};
	assign cy0 = {{15{py_s1[48]}}, py_s1[48:32]};

	always_ff @(posedge clk) begin
		px_s1 <= x_coord * $signed({1'b0, freq});
		py_s1 <= y_coord * $signed({1'b0, freq});
		a1_s2[0] <= 32'(cx0 * HASH_MUL_A);
		a1_s2[1] <= 32'((cx0 + 32'd1) * HASH_MUL_A);
		cy_s2[0] <= cy0;
		cy_s2[1] <= cy0 + 32'd1;
		tx_s2 <= px_s1[31:16];
		ty_s2 <= py_s1[31:16];
		tx_s3 <= tx_s2; ty_s3 <= ty_s2;
		tx_s4 <= tx_s3; ty_s4 <= ty_s3;
		tx_s5 <= tx_s4; ty_s5 <= ty_s4;
		tx_s6 <= tx_s5; ty_s6 <= ty_s5;
		ty_s7 <= ty_s6;
	end

	// corner j: bit 0 picks x0+1, bit 1 picks y0+1
	for (genvar j = 0; j < 4; j++) begin : g_corner
		localparam int XI = j & 1;
		localparam int YI = (j >> 1) & 1;
		logic [ANGLE_BITS-1:0] k;
		logic [1:0] quad;
		logic [ANGLE_BITS-3:0] r;
		logic signed [17:0] sv, cv;
		logic signed [16:0] dx, dy;
		logic signed [35:0] dsum;

		assign k    = h_s4[j][31 -: ANGLE_BITS];
		assign quad = k[ANGLE_BITS-1 -: 2];
		assign r    = k[ANGLE_BITS-3:0];
		assign sv   = $signed({1'b0, SIN_TAB[r]});
		assign cv   = $signed({1'b0, COS_TAB[r]});
		assign dx   = $signed({1'(XI), tx_s5});
		assign dy   = $signed({1'(YI), ty_s5});
		assign dsum = dx * gx_s5[j] + dy * gy_s5[j];

		always_ff @(posedge clk) begin
			a1_s3[j] <= a1_s2[XI];
			b1_s3[j] <= 32'((cy_s2[YI] ^ rot16(a1_s2[XI])) * HASH_MUL_B);
			h_s4[j]  <= 32'((a1_s3[j] ^ rot16(b1_s3[j])) * HASH_MUL_C);
			case (quad)
				2'd0: begin gx_s5[j] <= cv;  gy_s5[j] <= sv;  end
				2'd1: begin gx_s5[j] <= -sv; gy_s5[j] <= cv;  end
				2'd2: begin gx_s5[j] <= -cv; gy_s5[j] <= -sv; end
				default: begin gx_s5[j] <= sv; gy_s5[j] <= -cv; end
			endcase
			dot_s6[j] <= dsum[35:8];
		end
	end

	always_ff @(posedge clk) begin
		mx_s7[0] <= mix(dot_s6[0], dot_s6[1], tx_s6);
		mx_s7[1] <= mix(dot_s6[2], dot_s6[3], tx_s6);
		val_s8   <= mix(mx_s7[0], mx_s7[1], ty_s7);
	end

	assign value = val_s8;

endmodule

// ===== rtl/fractal_gradient_noise_2d.sv =====
// Top level: configuration registers, octave lanes, octave sum and saturation.
// One sample point (signed Q16.16 x_coord, y_coord) is taken on every cycle that
// start is high; busy never rises. Each point gives one noise_value (signed Q3.16,
// saturated) with done high for one cycle, in order. The result passes through
// the lane pipeline: coordinate scaling, three hash multiplies, gradient table,
// dot product and two lerp stages, then the sum. All octaves run in parallel lanes.
// Registers may be written only while idle.
module fractal_gradient_noise_2d import fgn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               done,
	output logic signed [19:0] noise_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	logic [2:0]  octave_count_q;
	logic [15:0] freq_q [MAX_OCTAVES];
	logic [LATENCY-2:0] vld_q;
	logic        done_q;
	logic signed [19:0] noise_q;
	q24_t        lane_val [MAX_OCTAVES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= 3'd2;
			freq_q[0] <= 16'd3277;
			freq_q[1] <= 16'd6554;
			freq_q[2] <= 16'd0;
			freq_q[3] <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OCT_COUNT: octave_count_q <= cfg_data[2:0];
				REG_FREQ_0:    freq_q[0] <= cfg_data;
				REG_FREQ_1:    freq_q[1] <= cfg_data;
				REG_FREQ_2:    freq_q[2] <= cfg_data;
				REG_FREQ_3:    freq_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
		fgn_octave u_oct (
			.clk     (clk),
			.x_coord (x_coord),
			.y_coord (y_coord),
			.freq    (freq_q[i]),
			.value   (lane_val[i])
		);
	end

	// valid bits follow the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LATENCY-3:0], start && !busy};
			done_q <= vld_q[LATENCY-2];
		end
	end

	logic [2:0] n_oct;
	logic signed [29:0] sum;
	logic signed [29:0] rnd;
	logic signed [21:0] res;

	always_comb begin
		n_oct = (octave_count_q > 3'(MAX_OCTAVES)) ? 3'(MAX_OCTAVES) : octave_count_q;
		sum   = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (3'(i) < n_oct) sum = sum + 30'(lane_val[i]);
		end
		rnd = sum + 30'sd128;
		res = rnd[29:8];
	end

	always_ff @(posedge clk) begin
		if (res > 22'sd524287)       noise_q <= 20'sd524287;
		else if (res < -22'sd524288) noise_q <= -20'sd524288;
		else                         noise_q <= res[19:0];
	end

	assign done        = done_q;
	assign noise_value = noise_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, LATENCY) |-> (done == $past(start && !busy, LATENCY)))
		else $error("result beat not matched to accepted point");

	a_zero_oct: assert property (@(posedge clk) disable iff (!arst_n)
		(done && octave_count_q == 3'd0) |-> (noise_value == 20'sd0))
		else $error("zero octaves must give zero");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !busy)
		else $error("block must take a point every cycle");

endmodule

// ===== verif/tb_fractal_gradient_noise_2d.sv =====
// Self-checking testbench for the fractal gradient noise sampler.
`timescale 1ns / 1ps

module tb_fractal_gradient_noise_2d import fgn_pkg::*;;

	class noise_scoreboard;
		logic signed [19:0] pending[$];
		int errors;

		function void note_point(logic signed [19:0] v);
			pending = {pending, v};
		endfunction

		function void check_value(logic signed [19:0] got);
			logic signed [19:0] want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected noise_value, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: noise_value mismatch, expected %0d, actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic done;
	logic signed [19:0] noise_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	noise_scoreboard sb;
	int idle_cycles;

	logic [2:0] oct_count;
	logic [15:0] oct_freq[4];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fractal_gradient_noise_2d i_dut (.*);

	function automatic longint fl_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] hash_corner(longint cx, longint cy);
		logic [31:0] a, b;
		a = cx[31:0];
		b = cy[31:0];
		a = a * HASH_MUL_A;
		b = b ^ {a[15:0], a[31:16]};
		b = b * HASH_MUL_B;
		a = a ^ {b[15:0], b[31:16]};
		a = a * HASH_MUL_C;
		return a;
	endfunction

	function automatic void quarter_trig(longint unsigned phi,
			output longint s16, output longint c16);
		longint sacc, cacc;
		longint unsigned st, ct;
		sacc = 0;
		cacc = 0;
		st = phi;
		ct = 64'd1 << 30;
		for (int n = 1; n <= 10; n++) begin
			if (n % 2) begin
				sacc += st;
				cacc += ct;
			end else begin
				sacc -= st;
				cacc -= ct;
			end
			st = (st * phi) >> 30;
			st = ((st * phi) >> 30) / longint'((2 * n) * (2 * n + 1));
			ct = (ct * phi) >> 30;
			ct = ((ct * phi) >> 30) / longint'((2 * n - 1) * (2 * n));
		end
		if (sacc < 0) sacc = 0;
		if (cacc < 0) cacc = 0;
		s16 = (sacc + 8192) >>> 14;
		c16 = (cacc + 8192) >>> 14;
	endfunction

	function automatic longint gradient_dot(longint cx, longint cy, longint dx, longint dy);
		logic [31:0] h;
		logic [9:0] k;
		longint unsigned phi;
		longint s, c, gx, gy;
		h = hash_corner(cx, cy);
		k = h[31:22];
		phi = (longint'(k[7:0]) * HALF_PI_Q30) >> 8;
		quarter_trig(phi, s, c);
		case (k[9:8])
			2'd0: begin gx = c; gy = s; end
			2'd1: begin gx = -s; gy = c; end
			2'd2: begin gx = -c; gy = -s; end
			default: begin gx = s; gy = -c; end
		endcase
		return fl_shr(dx * gx + dy * gy, 8);
	endfunction

	function automatic longint lerp16(longint a, longint b, longint t);
		return fl_shr(a * (65536 - t) + b * t, 16);
	endfunction

	function automatic longint octave_noise(longint x, longint y, longint f);
		longint sx, sy, x0, y0, tx, ty;
		sx = fl_shr(x * f, 16);
		sy = fl_shr(y * f, 16);
		x0 = fl_shr(sx, 16);
		y0 = fl_shr(sy, 16);
		tx = sx - x0 * 65536;
		ty = sy - y0 * 65536;
		return lerp16(
			lerp16(gradient_dot(x0, y0, tx, ty), gradient_dot(x0 + 1, y0, tx - 65536, ty), tx),
			lerp16(gradient_dot(x0, y0 + 1, tx, ty - 65536),
				gradient_dot(x0 + 1, y0 + 1, tx - 65536, ty - 65536), tx), ty);
	endfunction

	function automatic logic signed [19:0] predict_noise(logic signed [31:0] x,
			logic signed [31:0] y);
		int n;
		longint sum, r;
		n = (oct_count > MAX_OCTAVES) ? MAX_OCTAVES : oct_count;
		sum = 0;
		for (int i = 0; i < n; i++)
			sum += octave_noise(x, y, oct_freq[i]);
		r = fl_shr(sum + 128, 8);
		if (r > 524287) r = 524287;
		if (r < -524288) r = -524288;
		return r[19:0];
	endfunction

	// drops start only when the drawn gap is nonzero
	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_OCT_COUNT) oct_count = val[2:0];
		else if (idx <= REG_FREQ_3) oct_freq[idx - 1] = val;
		@(posedge clk);
	endtask

	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit gaps);
		start <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_point(predict_noise(x, y));
		if (gaps && $urandom_range(0, 2) == 0) random_gap();
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2000000)) - 1000000;
			2: return {$urandom_range(0, 15) == 0 ? 16'h8000 : 16'h7fff, 16'($urandom)};
			default: return {16'($signed($urandom_range(0, 20)) - 10), 16'($urandom)};
		endcase
	endfunction

	// results: one per accepted point, never held off
	always @(posedge clk) begin
		if (arst_n && done) sb.check_value(noise_value);
	end

	always @(posedge clk) begin
		if (start && !busy || done || cfg_valid && cfg_ready) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] edge_vals[6];
		sb = new();
		oct_count = 3'd2;
		oct_freq = '{16'd3277, 16'd6554, 16'd0, 16'd0};
		edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
			32'hffff_0000, 32'h0001_0000};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, edges and negative integer cells
		foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[5 - i], 1'b0);
		send_point(32'hfffd_0000, 32'h0002_8000, 1'b0);
		start <= 1'b0;
		drain();
		write_reg(REG_OCT_COUNT, 16'd4);
		write_reg(REG_FREQ_0, 16'hffff);
		write_reg(REG_FREQ_1, 16'h0);
		write_reg(REG_FREQ_2, 16'h8000);
		write_reg(REG_FREQ_3, 16'h1234);
		write_reg(3'd6, 16'h5555);
		foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[i], 1'b0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		start <= 1'b0;
		drain();
		write_reg(REG_OCT_COUNT, 16'd0);
		send_point(32'h1234_5678, 32'h8765_4321, 1'b0);
		start <= 1'b0;
		drain();
		write_reg(REG_OCT_COUNT, 16'd7);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_point(32'hfff0_0000, 32'h000f_ffff, 1'b0);
		start <= 1'b0;
		drain();

		for (int phase = 0; phase < 13; phase++) begin
			write_reg(REG_OCT_COUNT, 16'($urandom_range(0, 7)));
			for (int r = 0; r < 4; r++)
				write_reg(3'(REG_FREQ_0 + r), ($urandom_range(0, 4) == 0) ?
					(($urandom_range(0, 1)) ? 16'hffff : 16'h0) : 16'($urandom));
			for (int n = 0; n < 150; n++) send_point(rand_coord(), rand_coord(), phase != 4);
			start <= 1'b0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
